// ===== design/sufl_pkg.sv =====
`default_nettype none
package sufl_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = SAMPLE_BITS - 1;
  localparam int PROD_W       = 2 * SAMPLE_BITS;
  localparam int WIDE_W       = 40;
  localparam int GAIN_W       = 2 * SAMPLE_BITS;
  localparam int CLAMP_W      = SAMPLE_BITS - 1;
  localparam int GAIN_SHIFT   = 4;
  localparam int NUM_OUT      = 5;
  localparam int QUEUE_DEPTH  = 4;
  localparam int DEF_TAPS     = 31;
  localparam int DEF_CHANNELS = 5;
  localparam int COEF_COUNT   = 16;

  localparam int IN_W       = 2 * SAMPLE_BITS;
  localparam int OUT_W      = NUM_OUT * SAMPLE_BITS;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_LSB    = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - REG_LSB;

  localparam logic [CLAMP_W-1:0] CLAMP_RESET = '1;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 48'd13941452358476;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILTER_ENABLE       = 3'd0,
    REG_CLAMP_LEVEL         = 3'd1,
    REG_GAIN_FRONT_LEFT     = 3'd2,
    REG_GAIN_FRONT_RIGHT    = 3'd3,
    REG_GAIN_SURROUND_LEFT  = 3'd4,
    REG_GAIN_SURROUND_RIGHT = 3'd5,
    REG_GAIN_CENTER         = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                             filter_enable;
    logic [CLAMP_W-1:0]               clamp_level;
    logic [NUM_OUT-1:0][GAIN_W-1:0]   gain;
  } cfg_t;

  // Low-pass taps by distance from the center, 1.23, rounded to nearest.
  localparam sample_t COEF_TABLE [COEF_COUNT] = '{
    24'sd7223215, 24'sd1090801, -24'sd900217, 24'sd670256,
    -24'sd456275, 24'sd283572, -24'sd158123, 24'sd75265,
    -24'sd25835, -24'sd22, 24'sd10860, -24'sd13179,
    24'sd11408, -24'sd8252, 24'sd5150, -24'sd2714
  };

  function automatic sample_t coef_tap(input int tap, input int half);
    int tap_dist;
    tap_dist = tap - half;
    if (tap_dist < 0) tap_dist = -tap_dist;
    if (tap_dist < COEF_COUNT) return COEF_TABLE[tap_dist[3:0]];
    return '0;
  endfunction

  // Floor a 1.23 x 1.23 product back to 1.23 and saturate.
  function automatic sample_t sat_frac(input prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    if (!s[PROD_W-1] && (|s[PROD_W-2:SAMPLE_BITS-1])) return {1'b0, {FRAC_BITS{1'b1}}};
    if (s[PROD_W-1] && !(&s[PROD_W-2:SAMPLE_BITS-1])) return {1'b1, {FRAC_BITS{1'b0}}};
    return s[SAMPLE_BITS-1:0];
  endfunction

  function automatic sample_t sat_wide(input wide_t v);
    if (!v[WIDE_W-1] && (|v[WIDE_W-2:SAMPLE_BITS-1])) return {1'b0, {FRAC_BITS{1'b1}}};
    if (v[WIDE_W-1] && !(&v[WIDE_W-2:SAMPLE_BITS-1])) return {1'b1, {FRAC_BITS{1'b0}}};
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic wide_t sext_wide(input sample_t v);
    return {{(WIDE_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic sample_t clamp_sample(input sample_t v, input logic [CLAMP_W-1:0] t);
    sample_t tpos;
    sample_t tneg;
    tpos = {1'b0, t};
    tneg = -tpos;
    if (v > tpos) return tpos;
    if (v < tneg) return tneg;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/stereo_upmix_fir_lowpass.sv =====
// Stereo to five-channel upmix with a per-channel low-pass FIR.
// Frame rate: filter on, set by the single tap MAC in the back end; filter off, set by
//   the mixer.
// Reset: synchronous, active high; registers go to defaults, then a clearing pass over all
//   CH*TAPS words (155 at defaults) zeroes the delay lines with s_tready held low.
`default_nettype none
module stereo_upmix_fir_lowpass #(
  parameter int TAPS     = sufl_pkg::DEF_TAPS,
  parameter int CHANNELS = sufl_pkg::DEF_CHANNELS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_tdata: left_sample [23:0], right_sample [47:24]
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [sufl_pkg::IN_W-1:0]       s_tdata,
  // m_tdata: front_left_out [23:0], front_right_out [47:24], surround_left_out [71:48],
  //          surround_right_out [95:72], center_out [119:96]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [sufl_pkg::OUT_W-1:0]           m_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sufl_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [sufl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sufl_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import sufl_pkg::*;

  cfg_t              cfg;
  reg_index_t        reg_idx;
  logic              cfg_wr;
  logic              clearing;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  sample_t           q_wdata;
  logic [SAMPLE_BITS-1:0] q_rdata;

  // Register file: 64-bit slots at byte address 8*index, written in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[CFG_ADDR_W-1:REG_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable <= 1'b1;
      cfg.clamp_level   <= CLAMP_RESET;
      for (int i = 0; i < NUM_OUT; i++) cfg.gain[i] <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FILTER_ENABLE:       cfg.filter_enable <= pwdata[0];
        REG_CLAMP_LEVEL:         cfg.clamp_level   <= pwdata[CLAMP_W-1:0];
        REG_GAIN_FRONT_LEFT:     cfg.gain[0]       <= pwdata[GAIN_W-1:0];
        REG_GAIN_FRONT_RIGHT:    cfg.gain[1]       <= pwdata[GAIN_W-1:0];
        REG_GAIN_SURROUND_LEFT:  cfg.gain[2]       <= pwdata[GAIN_W-1:0];
        REG_GAIN_SURROUND_RIGHT: cfg.gain[3]       <= pwdata[GAIN_W-1:0];
        REG_GAIN_CENTER:         cfg.gain[4]       <= pwdata[GAIN_W-1:0];
        default: ;  // drop writes to unmapped slots
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FILTER_ENABLE:       prdata = CFG_DATA_W'(cfg.filter_enable);
      REG_CLAMP_LEVEL:         prdata = CFG_DATA_W'(cfg.clamp_level);
      REG_GAIN_FRONT_LEFT:     prdata = CFG_DATA_W'(cfg.gain[0]);
      REG_GAIN_FRONT_RIGHT:    prdata = CFG_DATA_W'(cfg.gain[1]);
      REG_GAIN_SURROUND_LEFT:  prdata = CFG_DATA_W'(cfg.gain[2]);
      REG_GAIN_SURROUND_RIGHT: prdata = CFG_DATA_W'(cfg.gain[3]);
      REG_GAIN_CENTER:         prdata = CFG_DATA_W'(cfg.gain[4]);
      default:                 prdata = '0;
    endcase
  end

  // Front end: take a stereo request, run the gain mix one channel at a time on a shared
  // multiplier, and hand each mixed, saturated and clamped sample to the queue.
  sufl_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Short queue of mixed samples, in channel order; lets the mixer run ahead of the filter.
  sufl_queue #(
    .DEPTH(QUEUE_DEPTH),
    .W    (SAMPLE_BITS)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: per channel, store the sample in its circular delay line and walk all taps
  // through one MAC if the filter is on; saturate, clamp and gather the five results.
  sufl_back #(
    .TAPS    (TAPS),
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // No new request while the delay lines are still being cleared.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input taken during delay line clear");

  // Mixer must hold a sample while the queue is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

  // Filter side pops only real entries.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue underflow");

endmodule
`default_nettype wire

// ===== design/sufl_queue.sv =====
`default_nettype none
module sufl_queue #(
  parameter int DEPTH = 4,
  parameter int W     = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/sufl_front.sv =====
`default_nettype none
module sufl_front #(
  parameter int CHANNELS = sufl_pkg::DEF_CHANNELS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sufl_pkg::cfg_t                 cfg,
  input  wire logic                           clearing,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sufl_pkg::IN_W-1:0]      in_data,
  input  wire logic                           q_full,
  output logic                                q_push,
  output logic [sufl_pkg::SAMPLE_BITS-1:0]    q_wdata
);
  import sufl_pkg::*;

  localparam int NCH  = (CHANNELS < NUM_OUT) ? CHANNELS : NUM_OUT;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCH - 1);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_MUL_L = 4'b0010,
    F_MUL_R = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t           state;
  fstate_t           state_next;
  sample_t           left;
  sample_t           right;
  sample_t           mix_l;
  prod_t             prod;
  logic [CH_W-1:0]   ch;
  logic [GAIN_W-1:0] gain_sel;
  sample_t           mul_a;
  sample_t           mul_b;
  sample_t           mix_y;

  assign in_ready = (state == F_IDLE) && !clearing;

  always_comb begin
    gain_sel = '0;
    for (int i = 0; i < NCH; i++) begin
      if (ch == CH_W'(i)) gain_sel = cfg.gain[i];
    end
  end

  // One shared multiplier: left gain first, right gain next.
  always_comb begin
    mul_a = (state == F_MUL_L) ? left : right;
    mul_b = (state == F_MUL_L) ? gain_sel[SAMPLE_BITS-1:0] : gain_sel[GAIN_W-1:SAMPLE_BITS];
  end

  assign mix_y = clamp_sample(
      sat_wide(sext_wide(mix_l) + (sext_wide(sat_frac(prod)) <<< GAIN_SHIFT)),
      cfg.clamp_level);

  assign q_push  = (state == F_PUSH) && !q_full;
  assign q_wdata = mix_y;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (in_valid && in_ready) state_next = F_MUL_L;
      F_MUL_L: state_next = F_MUL_R;
      F_MUL_R: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_next = (ch == LAST_CH) ? F_IDLE : F_MUL_L;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) ch <= '0;
      else if (q_push && ch != LAST_CH) ch <= ch + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      left  <= in_data[SAMPLE_BITS-1:0];
      right <= in_data[IN_W-1:SAMPLE_BITS];
    end
    if (state == F_MUL_L || state == F_MUL_R) prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (state == F_MUL_R) mix_l <= sat_frac(prod);
  end
endmodule
`default_nettype wire

// ===== design/sufl_back.sv =====
`default_nettype none
module sufl_back #(
  parameter int TAPS     = sufl_pkg::DEF_TAPS,
  parameter int CHANNELS = sufl_pkg::DEF_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sufl_pkg::cfg_t                cfg,
  output logic                               clearing,
  input  wire logic                          q_empty,
  input  wire logic [sufl_pkg::SAMPLE_BITS-1:0] q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sufl_pkg::OUT_W-1:0]         out_data
);
  import sufl_pkg::*;

  localparam int NCH       = (CHANNELS < NUM_OUT) ? CHANNELS : NUM_OUT;
  localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MEM_DEPTH = NCH * TAPS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = $clog2(TAPS);
  localparam int HALF      = (TAPS - 1) / 2;
  localparam int ACC_W     = SAMPLE_BITS + $clog2(TAPS);
  localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NCH - 1);
  localparam logic [PW-1:0]   LAST_TAP  = PW'(TAPS - 1);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(MEM_DEPTH - 1);
  localparam logic [AW-1:0]   TAPS_A    = AW'(TAPS);

  typedef enum logic [5:0] {
    B_CLEAR  = 6'b000001,
    B_POP    = 6'b000010,
    B_WRITE  = 6'b000100,
    B_MAC    = 6'b001000,
    B_FINISH = 6'b010000,
    B_EMIT   = 6'b100000
  } bstate_t;

  bstate_t                 state;
  bstate_t                 state_next;
  sample_t                 mem [MEM_DEPTH];
  sample_t                 rdata;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  sample_t                 mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [AW-1:0]           clr_addr;
  logic [AW-1:0]           base;
  logic [CH_W-1:0]         ch;
  logic [PW-1:0]           wpos [NCH];
  logic [PW-1:0]           pos_cur;
  logic [PW-1:0]           pos_inc;
  logic [PW-1:0]           pos_new;
  logic [PW-1:0]           idx;
  logic [PW-1:0]           idx_inc;
  logic [PW-1:0]           tap;
  sample_t                 y_hold;
  sample_t                 coef1;
  logic                    v1;
  logic                    v2;
  prod_t                   prod;
  logic signed [ACC_W-1:0] acc;
  sample_t                 result;
  sample_t                 res [NCH];
  logic                    finish_go;
  logic                    emit_go;

  assign clearing = (state == B_CLEAR);
  assign q_pop    = (state == B_POP) && !q_empty;

  always_comb begin
    pos_cur = '0;
    for (int i = 0; i < NCH; i++) begin
      if (ch == CH_W'(i)) pos_cur = wpos[i];
    end
  end

  assign pos_inc   = (pos_cur == LAST_TAP) ? '0 : pos_cur + 1'b1;
  assign idx_inc   = (idx == LAST_TAP) ? '0 : idx + 1'b1;
  assign finish_go = (state == B_FINISH) && !v1 && !v2;
  assign emit_go   = (state == B_EMIT) && (!out_valid || out_ready);
  assign result    = clamp_sample(sat_wide(WIDE_W'(acc)), cfg.clamp_level);

  always_comb begin
    mem_we    = clearing || (state == B_WRITE);
    mem_waddr = clearing ? clr_addr : base + AW'(pos_cur);
    mem_wdata = clearing ? '0 : y_hold;
    mem_raddr = base + AW'(idx);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR:  if (clr_addr == LAST_ADDR) state_next = B_POP;
      B_POP: begin
        if (!q_empty) state_next = cfg.filter_enable ? B_WRITE : B_FINISH;
      end
      B_WRITE:  state_next = B_MAC;
      B_MAC:    if (tap == '0) state_next = B_FINISH;
      B_FINISH: if (finish_go) state_next = (ch == LAST_CH) ? B_EMIT : B_POP;
      B_EMIT:   if (emit_go) state_next = B_POP;
      default:  state_next = B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      ch        <= '0;
      base      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NCH; i++) wpos[i] <= '0;
    end else begin
      state <= state_next;
      v1    <= (state == B_MAC);
      v2    <= v1;
      if (clearing) clr_addr <= clr_addr + 1'b1;
      if (finish_go) begin
        if (cfg.filter_enable) begin
          for (int i = 0; i < NCH; i++) begin
            if (ch == CH_W'(i)) wpos[i] <= pos_new;
          end
        end
        if (ch != LAST_CH) begin
          ch   <= ch + 1'b1;
          base <= base + TAPS_A;
        end
      end
      if (emit_go) begin
        ch   <= '0;
        base <= '0;
      end
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Tap walk, MAC pipeline: address, read data, product, accumulate.
  always_ff @(posedge clk) begin
    if (q_pop) y_hold <= q_rdata;
    if (state == B_WRITE) begin
      pos_new <= pos_inc;
      idx     <= pos_inc;
      tap     <= LAST_TAP;
    end else if (state == B_MAC) begin
      idx <= idx_inc;
      tap <= tap - 1'b1;
    end
    coef1 <= coef_tap(int'(tap), HALF);
    if (v1) prod <= PROD_W'(coef1) * PROD_W'(rdata);
    if (q_pop) acc <= ACC_W'($signed(q_rdata));
    else if (state == B_WRITE) acc <= '0;
    else if (v2) acc <= acc + ACC_W'(sat_frac(prod));
    if (finish_go) begin
      for (int i = 0; i < NCH; i++) begin
        if (ch == CH_W'(i)) res[i] <= result;
      end
    end
    if (emit_go) begin
      for (int i = 0; i < NUM_OUT; i++) begin
        out_data[i*SAMPLE_BITS +: SAMPLE_BITS] <= (i < NCH) ? res[i] : '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/upmix_checker.sv =====
`timescale 1ns / 100ps
// Watches the frame, result and register buses of the upmix block. Keeps its own copy of
// the mixer settings and of the five low-pass delay lines. Predicts every result frame and
// compares it, channel by channel, with what the block returns.
module upmix_checker
  import sufl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_W-1:0]      m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int          TAP_COUNT    = 31;
  localparam int          MID_TAP      = (TAP_COUNT - 1) / 2;
  localparam int          PRODUCT_SHR  = 23;
  localparam int          PRINT_CAP    = 40;
  localparam longint      PEAK         = 64'sd8388607;
  localparam longint      TROUGH       = -64'sd8388608;
  localparam logic [47:0] GAIN_DEFAULT = 48'd13941452358476;

  // Low-pass taps by distance from the center tap, 1.23.
  localparam longint LP_TAPS [16] = '{
    7223215, 1090801, -900217, 670256, -456275, 283572, -158123, 75265,
    -25835, -22, 10860, -13179, 11408, -8252, 5150, -2714
  };

  string chan_label [NUM_OUT] = '{
    "front_left", "front_right", "surround_left", "surround_right", "center"
  };

  logic             filt_on;
  logic [22:0]      clamp_mag;
  logic [47:0]      gain_pair [NUM_OUT];
  longint           hist [NUM_OUT][TAP_COUNT];
  int               head [NUM_OUT];
  logic [OUT_W-1:0] mix_expect_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    // keep the log readable when something breaks badly; every failure still counts
    if (fail_count < PRINT_CAP) $display("%0t ns  MISMATCH  %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint to_range(input longint v);
    if (v > PEAK) return PEAK;
    if (v < TROUGH) return TROUGH;
    return v;
  endfunction

  function automatic longint limit_mag(input longint v);
    longint t;
    t = clamp_mag;
    if (v > t) return t;
    if (v < -t) return -t;
    return v;
  endfunction

  // 1.23 times 1.23, floored back to 1.23
  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> PRODUCT_SHR;
  endfunction

  function automatic longint tap_coef(input int i);
    int d;
    d = i - MID_TAP;
    if (d < 0) d = -d;
    return (d < 16) ? LP_TAPS[d] : 64'sd0;
  endfunction

  function automatic longint lowpass_step(input int ch, input longint x);
    longint acc;
    int     p;
    int     idx;
    acc = 0;
    p = head[ch];
    hist[ch][p] = x;
    p = (p + 1 == TAP_COUNT) ? 0 : p + 1;
    // oldest sample first, it meets the last coefficient
    for (int k = 0; k < TAP_COUNT; k++) begin
      idx = p + k;
      if (idx >= TAP_COUNT) idx -= TAP_COUNT;
      acc += to_range(fmul(tap_coef(TAP_COUNT - 1 - k), hist[ch][idx]));
    end
    head[ch] = p;
    return acc;
  endfunction

  function automatic logic [OUT_W-1:0] predict_frame(input sample_t l, input sample_t r);
    logic [OUT_W-1:0] word;
    sample_t          gl;
    sample_t          gr;
    longint           y;
    word = '0;
    for (int c = 0; c < NUM_OUT; c++) begin
      gl = gain_pair[c][23:0];
      gr = gain_pair[c][47:24];
      // right gain is stored divided by 16
      y = to_range(fmul(l, gl)) + 16 * to_range(fmul(r, gr));
      y = limit_mag(to_range(y));
      if (filt_on) y = lowpass_step(c, y);
      y = limit_mag(to_range(y));
      word[c*SAMPLE_BITS +: SAMPLE_BITS] = y[SAMPLE_BITS-1:0];
    end
    return word;
  endfunction

  always @(posedge clk) begin : watch
    logic [REG_IDX_W-1:0] idx;
    logic [OUT_W-1:0]     want;
    if (rst) begin
      filt_on   = 1'b1;
      clamp_mag = '1;
      for (int c = 0; c < NUM_OUT; c++) begin
        gain_pair[c] = GAIN_DEFAULT;
        head[c]      = 0;
        for (int t = 0; t < TAP_COUNT; t++) hist[c][t] = 0;
      end
      mix_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[CFG_ADDR_W-1:REG_LSB];
        case (idx)
          REG_FILTER_ENABLE: filt_on = pwdata[0];
          REG_CLAMP_LEVEL:   clamp_mag = pwdata[22:0];
          REG_GAIN_FRONT_LEFT, REG_GAIN_FRONT_RIGHT, REG_GAIN_SURROUND_LEFT,
          REG_GAIN_SURROUND_RIGHT, REG_GAIN_CENTER:
            gain_pair[int'(idx) - int'(REG_GAIN_FRONT_LEFT)] = pwdata[47:0];
          default: ;
        endcase
      end
      // compare before predicting, a result never belongs to a request of the same edge
      if (m_tvalid && m_tready) begin
        if (mix_expect_q.size() == 0) begin
          report_mismatch($sformatf("result frame %h with nothing expected", m_tdata));
        end else begin
          want = mix_expect_q.pop_front();
          for (int c = 0; c < NUM_OUT; c++) begin
            if (m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] !== want[c*SAMPLE_BITS +: SAMPLE_BITS])
              report_mismatch($sformatf("%s: got %0d, want %0d", chan_label[c],
                $signed(m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
                $signed(want[c*SAMPLE_BITS +: SAMPLE_BITS])));
          end
        end
      end
      if (s_tvalid && s_tready)
        mix_expect_q.push_back(predict_frame(s_tdata[SAMPLE_BITS-1:0],
                                             s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
    end
    outstanding = mix_expect_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import sufl_pkg::*;

  localparam int          REG_UNUSED   = 7;      // decodes to no register
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 242;
  localparam int          DRAIN_LIMIT  = 50000;
  localparam int          TAIL_CYCLES  = 200;    // wait after the drain for any stray result
  localparam sample_t     SAMPLE_MAX   = 24'sh7FFFFF;
  localparam sample_t     SAMPLE_MIN   = 24'sh800000;
  localparam logic [23:0] GAIN_NEG_ONE = 24'h800000;
  localparam logic [23:0] GAIN_POS_MAX = 24'h7FFFFF;
  localparam logic [47:0] GAIN_NOMINAL = 48'd13941452358476;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;   // left_sample [23:0], right_sample [47:24]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;   // front_left, front_right, surround_left,
                                    // surround_right, center; 24 bits each from bit 0
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   fail_count;
  int   outstanding;
  logic steady;   // high: no gaps on either side

  stereo_upmix_fir_lowpass u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  upmix_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run: every frame paying the full filter
  // latency, the longest sender gap and the longest receiver stall.
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 300);
  endfunction

  // Spread samples over small, mid-size, full-scale and corner values so the
  // filter sees both clean signal and saturation.
  function automatic sample_t rand_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0: return {{9{raw[15]}}, raw[14:0]};
      1: return {{5{raw[19]}}, raw[18:0]};
      2: begin
        case (raw[31:29])
          3'd0:    return SAMPLE_MAX;
          3'd1:    return SAMPLE_MIN;
          3'd2:    return '0;
          3'd3:    return 24'sd1;
          3'd4:    return -24'sd1;
          default: return raw[23:0];
        endcase
      end
      default: return raw[23:0];
    endcase
  endfunction

  // Gain pair word, right half holds the right gain over 16. Upper bits carry junk
  // the register must drop.
  function automatic logic [63:0] rand_gain_word();
    logic [63:0] w;
    logic [23:0] gl;
    logic [23:0] gr;
    w  = {$urandom, $urandom};
    gl = w[23:0];
    gr = w[47:24];
    case ($urandom_range(0, 4))
      0: ;
      1, 2: begin
        // moderate gains keep most sums out of saturation
        gl = {{3{gl[20]}}, gl[20:0]};
        gr = {{7{gr[16]}}, gr[16:0]};
      end
      3: {gr, gl} = GAIN_NOMINAL;
      default: begin
        gl = w[48] ? GAIN_NEG_ONE : GAIN_POS_MAX;
        gr = w[49] ? GAIN_NEG_ONE : '0;
      end
    endcase
    return {w[63:48], gr, gl};
  endfunction

  // Setup, then access until pready, then drop back to idle.
  task automatic reg_write(input int unsigned idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx << REG_LSB);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_gains(input logic [63:0] value);
    for (int g = 0; g < NUM_OUT; g++) reg_write(int'(REG_GAIN_FRONT_LEFT) + g, value);
  endtask

  // Offer one stereo request; hold tvalid high across back-to-back requests.
  task automatic send_frame(input sample_t l, input sample_t r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop tvalid and wait for every predicted frame to come back.
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Receiver: random stalls, except in the steady stretch.
  initial begin : sink
    int n;
    m_tready <= 1'b0;
    forever begin
      if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] word;
    int          n;
    steady   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: filter on, full-scale clamp, nominal gains. The block clears its
    // delay lines first; send_frame simply waits out the held-off tready.
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame('0, '0);
    send_frame(24'sh555555, 24'shAAAAAA);
    send_frame(24'sd1, -24'sd1);
    wait_results_done();

    // Minus one on both gains with the filter bypassed: minus one times minus one
    // must saturate to the largest positive value.
    write_all_gains({16'h0, GAIN_NEG_ONE, GAIN_NEG_ONE});
    reg_write(REG_FILTER_ENABLE, 64'd0);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, '0);
    wait_results_done();

    // Largest positive gains with the clamp at zero: everything collapses to zero.
    write_all_gains({16'h0, GAIN_POS_MAX, GAIN_POS_MAX});
    reg_write(REG_CLAMP_LEVEL, 64'd0);
    send_frame(rand_sample(), rand_sample());
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    wait_results_done();

    // A write to the unused index must change nothing; bring the filter back on
    // with a quarter-scale clamp and random gains.
    reg_write(REG_UNUSED, {$urandom, $urandom});
    reg_write(REG_CLAMP_LEVEL, 64'h20_0000);
    reg_write(REG_FILTER_ENABLE, 64'd1);
    for (int g = 0; g < NUM_OUT; g++)
      reg_write(int'(REG_GAIN_FRONT_LEFT) + g, rand_gain_word());
    repeat (4) send_frame(rand_sample(), rand_sample());

    // Random phases, each under its own settings. Registers change only once the
    // block has handed back every frame.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_results_done();
      steady = (ph == 2);
      word = {$urandom, $urandom};
      word[0] = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      reg_write(REG_FILTER_ENABLE, word);
      word = {$urandom, $urandom};
      case (ph)
        0, 3:    word[22:0] = '1;
        4:       word[22:0] = '0;
        5:       word[22:0] = {2'b11, word[20:0]};
        default: ;
      endcase
      reg_write(REG_CLAMP_LEVEL, word);
      for (int g = 0; g < NUM_OUT; g++)
        reg_write(int'(REG_GAIN_FRONT_LEFT) + g, rand_gain_word());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender once mid-phase until the block has drained completely
        if (ph == 1 && i == PHASE_ITEMS / 2) wait_results_done();
        send_frame(rand_sample(), rand_sample());
      end
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain, bounded, then give the block one frame of latency to show any stray result.
    n = 0;
    while (outstanding != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
